// ===== sv/stq_pkg.sv =====
// ---------------------------------------------------------------------------
// stq_pkg
// Shared codes and control/status types for the sorted timer queue.
// ---------------------------------------------------------------------------
package stq_pkg;

	// Operation codes
	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_ADJUST = 2'd1,
		FN_DELETE = 2'd2,
		FN_TICK   = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_DUP       = 2'd3
	} status_t;

	// Most expired timers released by one tick
	localparam int unsigned RESULT_LIMIT = 64;
	localparam int unsigned CNT_W        = $clog2(RESULT_LIMIT + 1);

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture request fields
		logic remove;  // close the gap at the matching cell
		logic insert;  // open a gap and place the captured timer
		logic pop;     // drop the head cell
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic match;     // captured handle is queued
		logic full;      // every cell holds a timer
		logic head_exp;  // head timer has expired
		logic next_exp;  // second timer has expired
	} stat_t;

endpackage

// ===== sv/stq_if.sv =====
// ---------------------------------------------------------------------------
// stq_req_if / stq_rsp_if
// Valid/ready channels for requests and results of the timer queue.
// ---------------------------------------------------------------------------
interface stq_req_if #(parameter int HANDLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic [1:0]             func;
	logic [HANDLE_BITS-1:0] timer_handle;
	logic [31:0]            expiry_time;
	logic [31:0]            current_time;

	modport source (output valid, func, timer_handle, expiry_time, current_time,
		input ready);
	modport sink (input valid, func, timer_handle, expiry_time, current_time,
		output ready);
endinterface

interface stq_rsp_if #(parameter int HANDLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic [HANDLE_BITS-1:0] result_handle;
	logic                   expired_flag;
	logic [1:0]             status_code;
	logic                   last_of_run;

	modport source (output valid, result_handle, expired_flag, status_code,
		last_of_run, input ready);
	modport sink (input valid, result_handle, expired_flag, status_code,
		last_of_run, output ready);
endinterface

// ===== sv/stq_datapath.sv =====
// ---------------------------------------------------------------------------
// stq_datapath
// Row of sorted timer cells; shifts left to remove, right to insert.
// ---------------------------------------------------------------------------
module stq_datapath #(
	parameter int MAX_TIMERS  = 64,
	parameter int HANDLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stq_pkg::cmd_t          cmd,
	input  logic [HANDLE_BITS-1:0] req_handle,
	input  logic [31:0]            req_expiry,
	input  logic [31:0]            req_now,
	output stq_pkg::stat_t         stat,
	output logic [HANDLE_BITS-1:0] head_handle
);

	logic [HANDLE_BITS-1:0] hnd_q;
	logic [31:0]            exp_q;
	logic [31:0]            now_q;

	logic [MAX_TIMERS-1:0]  valid_q;
	logic [31:0]            cexp_q [MAX_TIMERS];
	logic [HANDLE_BITS-1:0] chnd_q [MAX_TIMERS];

	logic [MAX_TIMERS-1:0]  match;
	logic [MAX_TIMERS-1:0]  le;
	logic [MAX_TIMERS-1:0]  shl;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hnd_q <= req_handle;
			exp_q <= req_expiry;
			now_q <= req_now;
		end
	end

	// Per-cell compares
	always_comb begin
		for (int i = 0; i < MAX_TIMERS; i++) begin
			match[i] = valid_q[i] && (chnd_q[i] == hnd_q);
			le[i]    = valid_q[i] && (cexp_q[i] <= exp_q);
		end
	end

	// Cells at and above the match move down; pop moves every cell
	assign shl = cmd.pop ? {MAX_TIMERS{1'b1}} :
		(cmd.remove ? ~(match - {{(MAX_TIMERS-1){1'b0}}, 1'b1}) : '0);

	genvar g;
	generate
		for (g = 0; g < MAX_TIMERS; g++) begin : g_cell
			logic                   up_v;
			logic [31:0]            up_e;
			logic [HANDLE_BITS-1:0] up_h;
			logic                   dn_v;
			logic [31:0]            dn_e;
			logic [HANDLE_BITS-1:0] dn_h;
			logic                   boundary;

			if (g < MAX_TIMERS - 1) begin : g_up
				assign up_v = valid_q[g+1];
				assign up_e = cexp_q[g+1];
				assign up_h = chnd_q[g+1];
			end else begin : g_top
				assign up_v = 1'b0;
				assign up_e = cexp_q[g];
				assign up_h = chnd_q[g];
			end

			if (g > 0) begin : g_dn
				assign dn_v     = valid_q[g-1];
				assign dn_e     = cexp_q[g-1];
				assign dn_h     = chnd_q[g-1];
				assign boundary = le[g-1];
			end else begin : g_bot
				assign dn_v     = 1'b0;
				assign dn_e     = cexp_q[g];
				assign dn_h     = chnd_q[g];
				assign boundary = 1'b1;
			end

			// Occupancy
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q[g] <= 1'b0;
				end else if (shl[g]) begin
					valid_q[g] <= up_v;
				end else if (cmd.insert && !le[g]) begin
					valid_q[g] <= boundary ? 1'b1 : dn_v;
				end
			end

			// Cell payload
			always_ff @(posedge clk) begin
				if (shl[g]) begin
					cexp_q[g] <= up_e;
					chnd_q[g] <= up_h;
				end else if (cmd.insert && !le[g]) begin
					cexp_q[g] <= boundary ? exp_q : dn_e;
					chnd_q[g] <= boundary ? hnd_q : dn_h;
				end
			end
		end

		if (MAX_TIMERS > 1) begin : g_next
			assign stat.next_exp = valid_q[1] && (cexp_q[1] <= now_q);
		end else begin : g_nonext
			assign stat.next_exp = 1'b0;
		end
	endgenerate

	// Status
	assign stat.match    = |match;
	assign stat.full     = valid_q[MAX_TIMERS-1];
	assign stat.head_exp = valid_q[0] && (cexp_q[0] <= now_q);
	assign head_handle   = chnd_q[0];

endmodule

// ===== sv/stq_ctrl.sv =====
// ---------------------------------------------------------------------------
// stq_ctrl
// Sequencer for add/adjust/delete/tick and the result output register.
// ---------------------------------------------------------------------------
module stq_ctrl #(
	parameter int HANDLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic [1:0]             req_func,
	output logic                   req_ready,
	input  logic                   rsp_ready,
	output logic                   rsp_valid,
	output logic [HANDLE_BITS-1:0] rsp_handle,
	output logic                   rsp_expired,
	output logic [1:0]             rsp_status,
	output logic                   rsp_last,
	output stq_pkg::cmd_t          cmd,
	input  stq_pkg::stat_t         stat,
	input  logic [HANDLE_BITS-1:0] head_handle
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_INSERT, S_TICK} state_t;

	state_t                     state_q;
	stq_pkg::func_t             func_q;
	logic [stq_pkg::CNT_W-1:0]  n_q;
	logic                       accept;
	logic                       slot_free;
	logic                       tick_last;

	assign req_ready = (state_q == S_IDLE) && !rsp_valid;
	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid || rsp_ready;
	assign tick_last = !stat.next_exp ||
		(n_q == stq_pkg::CNT_W'(stq_pkg::RESULT_LIMIT - 1));

	// Datapath commands
	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		case (state_q)
			S_EXEC: begin
				case (func_q)
					stq_pkg::FN_ADD:
						cmd.insert = !stat.match && !stat.full;
					stq_pkg::FN_ADJUST, stq_pkg::FN_DELETE:
						cmd.remove = stat.match;
					default: ;
				endcase
			end
			S_INSERT: cmd.insert = 1'b1;
			S_TICK:   cmd.pop    = slot_free && stat.head_exp;
			default: ;
		endcase
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= stq_pkg::FN_ADD;
			n_q         <= '0;
			rsp_valid   <= 1'b0;
			rsp_handle  <= '0;
			rsp_expired <= 1'b0;
			rsp_status  <= stq_pkg::ST_OK;
			rsp_last    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// result leaves here; busy states start with it empty
					if (rsp_valid && rsp_ready)
						rsp_valid <= 1'b0;
					if (accept) begin
						func_q  <= stq_pkg::func_t'(req_func);
						n_q     <= '0;
						state_q <= (stq_pkg::func_t'(req_func) == stq_pkg::FN_TICK) ?
							S_TICK : S_EXEC;
					end
				end
				S_EXEC: begin
					rsp_handle  <= '0;
					rsp_expired <= 1'b0;
					rsp_last    <= 1'b1;
					if (func_q == stq_pkg::FN_ADD) begin
						rsp_status <= stat.match ? stq_pkg::ST_DUP :
							(stat.full ? stq_pkg::ST_FULL : stq_pkg::ST_OK);
						rsp_valid  <= 1'b1;
						state_q    <= S_IDLE;
					end else if (!stat.match) begin
						rsp_status <= stq_pkg::ST_NOT_FOUND;
						rsp_valid  <= 1'b1;
						state_q    <= S_IDLE;
					end else if (func_q == stq_pkg::FN_ADJUST) begin
						// removed now, re-placed next cycle
						rsp_status <= stq_pkg::ST_OK;
						state_q    <= S_INSERT;
					end else begin
						rsp_status <= stq_pkg::ST_OK;
						rsp_valid  <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_INSERT: begin
					rsp_valid   <= 1'b1;
					rsp_handle  <= '0;
					rsp_expired <= 1'b0;
					rsp_status  <= stq_pkg::ST_OK;
					rsp_last    <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_TICK: begin
					if (slot_free) begin
						rsp_valid  <= 1'b1;
						rsp_status <= stq_pkg::ST_OK;
						if (stat.head_exp) begin
							rsp_handle  <= head_handle;
							rsp_expired <= 1'b1;
							rsp_last    <= tick_last;
							n_q         <= n_q + 1'b1;
							if (tick_last)
								state_q <= S_IDLE;
						end else begin
							// nothing expired
							rsp_handle  <= '0;
							rsp_expired <= 1'b0;
							rsp_last    <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/sorted_timer_queue.sv =====
// ---------------------------------------------------------------------------
// sorted_timer_queue
// Timer list kept sorted by expiry in a shifting cell row.
//
//   channel | dir | fields
//   req     | in  | func, timer_handle, expiry_time, current_time
//   rsp     | out | result_handle, expired_flag, status_code, last_of_run
//
// Add and delete pass through the execute state; adjust also passes through
// the insert state (remove, then re-insert). Tick gives one non-expired
// result when nothing has expired, else one per expired timer; each pop is
// one shift of the cell row. One request at a time; req.ready is low while
// busy or while a result is still held. A stalled rsp holds the sequencer.
// Reset clears cell occupancy and controller state, not cell payloads.
// ---------------------------------------------------------------------------
module sorted_timer_queue #(
	parameter int MAX_TIMERS  = 64,
	parameter int HANDLE_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	stq_req_if.sink   req,
	stq_rsp_if.source rsp
);

	stq_pkg::cmd_t          cmd;
	stq_pkg::stat_t         stat;
	logic [HANDLE_BITS-1:0] head_handle;

	stq_ctrl #(.HANDLE_BITS(HANDLE_BITS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_func    (req.func),
		.req_ready   (req.ready),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_handle  (rsp.result_handle),
		.rsp_expired (rsp.expired_flag),
		.rsp_status  (rsp.status_code),
		.rsp_last    (rsp.last_of_run),
		.cmd         (cmd),
		.stat        (stat),
		.head_handle (head_handle)
	);

	stq_datapath #(.MAX_TIMERS(MAX_TIMERS), .HANDLE_BITS(HANDLE_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_handle  (req.timer_handle),
		.req_expiry  (req.expiry_time),
		.req_now     (req.current_time),
		.stat        (stat),
		.head_handle (head_handle)
	);

	// No new request while a result is pending
	a_ready_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid) else $error("ready with pending result");

	// Only tick results may be non-final, and they are expired timers
	a_nonlast_expired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last_of_run |-> rsp.expired_flag)
		else $error("non-final result without expired timer");

	// Insert, remove and pop never issued together
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.insert, cmd.remove, cmd.pop}) <= 1)
		else $error("conflicting shift commands");

endmodule
